/* sv/uer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the echo ranger
// Register indexes, status codes, field widths and the structs that carry
// configuration and per-tick results between the modules.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int unsigned SAMPLES_DEFAULT = 5;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam int unsigned TRIG_W    = 8;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned WIDTH_W   = 16;
    localparam int unsigned GAP_W     = 16;
    localparam int unsigned REFRESH_W = 20;
    localparam int unsigned TICKS_W   = 20;
    localparam int unsigned SUM_W     = 20;
    localparam int unsigned DIST_W    = 14;
    localparam int unsigned STATUS_W  = 3;

    // sum*10 always fits in this many bits (20-bit sum times ten)
    localparam int unsigned SUM10_W = 24;

    localparam int unsigned TICKS_PER_CM  = 58;
    localparam int unsigned PRE_LOW_TICKS = 2;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_START_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_WIDTH_TIMEOUT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_ECHO_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ECHO_WIDTH     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_GAP         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_GAP        = 3'd6;

    // per-measurement status codes
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ECHO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_width;
        logic [TIMEOUT_W-1:0] echo_start_timeout;
        logic [TIMEOUT_W-1:0] echo_width_timeout;
        logic [WIDTH_W-1:0]   min_echo_width;
        logic [WIDTH_W-1:0]   max_echo_width;
        logic [GAP_W-1:0]     sample_gap;
        logic [REFRESH_W-1:0] refresh_gap;
    } cfg_t;

    typedef struct packed {
        logic                trigger_level;
        logic [DIST_W-1:0]   distance_tenths;
        logic                distance_valid;
        logic [STATUS_W-1:0] sample_status;
    } res_t;

endpackage

/* sv/uer_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_cfg_regs: configuration register file
// Holds the seven timing and range registers; writes beyond the list drop.
// ----------------------------------------------------------------------------
module uer_cfg_regs
    import uer_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TRIGGER_WIDTH:      cfg_next.trigger_width      = wr_data[TRIG_W-1:0];
                REG_ECHO_START_TIMEOUT: cfg_next.echo_start_timeout = wr_data[TIMEOUT_W-1:0];
                REG_ECHO_WIDTH_TIMEOUT: cfg_next.echo_width_timeout = wr_data[TIMEOUT_W-1:0];
                REG_MIN_ECHO_WIDTH:     cfg_next.min_echo_width     = wr_data[WIDTH_W-1:0];
                REG_MAX_ECHO_WIDTH:     cfg_next.max_echo_width     = wr_data[WIDTH_W-1:0];
                REG_SAMPLE_GAP:         cfg_next.sample_gap         = wr_data[GAP_W-1:0];
                REG_REFRESH_GAP:        cfg_next.refresh_gap        = wr_data[REFRESH_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width      <= TRIG_W'(10);
            cfg_reg.echo_start_timeout <= TIMEOUT_W'(20000);
            cfg_reg.echo_width_timeout <= TIMEOUT_W'(30000);
            cfg_reg.min_echo_width     <= WIDTH_W'(116);
            cfg_reg.max_echo_width     <= WIDTH_W'(23200);
            cfg_reg.sample_gap         <= GAP_W'(200);
            cfg_reg.refresh_gap        <= REFRESH_W'(300000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/uer_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_step: per-tick ranging sequencer
// Phase machine, tick counter, echo width counter, width sum and average.
// Produces the result of the current tick and advances state on advance.
// ----------------------------------------------------------------------------
module uer_step
    import uer_pkg::*;
#(
    parameter int unsigned SAMPLES = SAMPLES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic echo,
    input  cfg_t cfg,
    output res_t res
);

    localparam int unsigned CNT_W   = $clog2(SAMPLES + 1);
    localparam int unsigned DIVISOR = SAMPLES * TICKS_PER_CM;
    localparam int unsigned SHIFT   = SUM10_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned PROD_W  = SUM_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(RECIP * 10);

    typedef enum logic [2:0] {
        PH_PRE_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_RISE,
        PH_MEASURE,
        PH_GAP,
        PH_REFRESH
    } phase_t;

    phase_t             phase_reg,   phase_next;
    logic [TICKS_W-1:0] ticks_reg,   ticks_next;
    logic [WIDTH_W-1:0] width_reg,   width_next;
    logic [SUM_W-1:0]   sum_reg,     sum_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [DIST_W-1:0]  dist_reg,    dist_next;

    logic [TICKS_W:0]   ticks_inc;
    logic [TRIG_W-1:0]  trig_len;
    logic [SUM_W-1:0]   sum_acc;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  quotient;
    logic               in_range;
    logic               done_round;

    assign ticks_inc = {1'b0, ticks_reg} + 1'b1;
    assign trig_len  = (cfg.trigger_width == '0) ? TRIG_W'(1) : cfg.trigger_width;
    assign in_range  = (width_reg >= cfg.min_echo_width) && (width_reg <= cfg.max_echo_width);

    // sum including the width that ends on this tick
    assign sum_acc = sum_reg + SUM_W'(width_reg);

    // divide by SAMPLES*58 through a scaled reciprocal, exact for every 20-bit
    // sum (sum*10 stays below 2^24)
    assign product  = PROD_W'(sum_acc) * PROD_W'(SCALE);
    assign quotient = product >> SHIFT;

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_inc[TICKS_W-1:0];
        width_next = width_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        dist_next  = dist_reg;
        done_round = 1'b0;
        res.trigger_level  = 1'b0;
        res.distance_valid = 1'b0;
        res.sample_status  = ST_NONE;

        case (phase_reg)
            PH_PRE_LOW:
            begin
                if (ticks_inc >= (TICKS_W+1)'(PRE_LOW_TICKS))
                begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                res.trigger_level = 1'b1;
                if (ticks_inc >= (TICKS_W+1)'(trig_len))
                begin
                    phase_next = PH_WAIT_RISE;
                    ticks_next = '0;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo)
                begin
                    width_next = WIDTH_W'(1);
                    phase_next = PH_MEASURE;
                    ticks_next = '0;
                end
                else if (ticks_inc > (TICKS_W+1)'(cfg.echo_start_timeout))
                begin
                    res.sample_status = ST_NO_ECHO;
                    phase_next = PH_PRE_LOW;
                    ticks_next = '0;
                end
            end
            PH_MEASURE:
            begin
                ticks_next = ticks_reg;
                if (echo)
                begin
                    if (width_reg >= cfg.echo_width_timeout)
                    begin
                        res.sample_status = ST_TOO_LONG;
                        phase_next = PH_PRE_LOW;
                        ticks_next = '0;
                    end
                    else
                    begin
                        width_next = width_reg + 1'b1;
                    end
                end
                else
                begin
                    if (in_range)
                    begin
                        res.sample_status = ST_ACCEPT;
                        sum_next   = sum_acc;
                        count_next = count_reg + 1'b1;
                        if (count_next >= CNT_W'(SAMPLES))
                        begin
                            dist_next = (quotient > PROD_W'(DIST_MAX)) ? DIST_MAX
                                                                       : quotient[DIST_W-1:0];
                            res.distance_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        res.sample_status = ST_RANGE;
                    end
                    ticks_next = '0;
                    if (cfg.sample_gap == '0)
                    begin
                        done_round = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                    end
                end
            end
            PH_GAP:
            begin
                if (ticks_inc >= (TICKS_W+1)'(cfg.sample_gap))
                begin
                    ticks_next = '0;
                    done_round = 1'b1;
                end
            end
            PH_REFRESH:
            begin
                if (ticks_inc >= (TICKS_W+1)'(cfg.refresh_gap))
                begin
                    phase_next = PH_PRE_LOW;
                    ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_PRE_LOW;
                ticks_next = '0;
            end
        endcase

        // end of a sample gap (or echo, if no gap): retrigger, or close the round (refresh unless zero)
        if (done_round)
        begin
            if (count_next >= CNT_W'(SAMPLES))
            begin
                sum_next   = '0;
                count_next = '0;
                phase_next = (cfg.refresh_gap == '0) ? PH_PRE_LOW : PH_REFRESH;
            end
            else
            begin
                phase_next = PH_PRE_LOW;
            end
        end

        res.distance_tenths = dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE_LOW;
            ticks_reg <= '0;
            width_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            dist_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            width_reg <= width_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            dist_reg  <= dist_next;
        end
    end

endmodule

/* sv/ultrasonic_echo_ranger_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit: echo-pulse ranging sequencer, one word per tick
// Input register, per-tick sequencer and result register.
// ----------------------------------------------------------------------------
// Feed one input word per microsecond tick carrying the sampled echo level;
// each word yields exactly one result word with the trigger drive for that
// tick, the held average distance in tenths of a centimetre, a strobe on the
// tick a new average appears and the status of a measurement that ends on
// that tick. The block takes one word every cycle unless the output stalls;
// each word passes the input register, then the result register, and is
// held there until taken. Between the two registers sits a single pass of
// the phase logic and the reciprocal multiply that forms the average. A full
// result register holds under output stall, as does the input register
// behind it; the input side stalls only while both are full and the output
// is stalled. Write configuration only while no word is in flight; cfg_ready
// is always high and writes to indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int unsigned SAMPLES = SAMPLES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   echo_level,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   trigger_level,
    output logic [DIST_W-1:0]      distance_tenths,
    output logic                   distance_valid,
    output logic [STATUS_W-1:0]    sample_status,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;

    logic in_valid_reg;
    logic echo_reg;
    logic out_valid_reg;
    logic advance;

    // move the held input word into the result register when it has room
    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    uer_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    uer_step #(
        .SAMPLES (SAMPLES)
    ) u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .echo    (echo_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input register: load whenever not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            echo_reg <= echo_level;
        end
    end

    // result register: hold while stalled, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign trigger_level   = res_reg.trigger_level;
    assign distance_tenths = res_reg.distance_tenths;
    assign distance_valid  = res_reg.distance_valid;
    assign sample_status   = res_reg.sample_status;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tick-by-tick check of the ultrasonic echo ranger
// Feeds echo words in bursts against a receiver that stalls on its own
// pattern. A local model of the ranging sequencer predicts every result
// word, and each word that leaves the block is compared field by field.
// A short scripted opening covers reset, zeroed registers and every status;
// random phases then shape echo pulses around the programmed windows.
// ----------------------------------------------------------------------------
module testbench;
    import uer_pkg::*;

    localparam int unsigned AVG_COUNT   = SAMPLES_DEFAULT;
    localparam int unsigned MAX_REPORTS = 10;
    // the block holds a word in its input and result registers; leave margin on top
    localparam int unsigned DRAIN_TICKS = 8;
    localparam int unsigned SCRIPT_ROWS = 31;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PEAK_PHASE  = 2;

    // index past the end of the register list; the block must drop it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [2:0] {
        RNG_PRE_LOW,
        RNG_TRIG_HIGH,
        RNG_WAIT_RISE,
        RNG_MEASURE,
        RNG_GAP,
        RNG_REFRESH
    } ranger_phase_t;

    // one line of the scripted opening: a register write or one echo word,
    // the latter optionally with its result spelled out
    typedef struct packed {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   echo;
        bit                     typed;
        res_t                   word;
    } script_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   echo_level;
    logic                   out_valid;
    logic                   out_stall;
    logic                   trigger_level;
    logic [DIST_W-1:0]      distance_tenths;
    logic                   distance_valid;
    logic [STATUS_W-1:0]    sample_status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // model of the sequencer: registers and running state
    cfg_t                   ranger_cfg;
    ranger_phase_t          phase_now;
    logic [TICKS_W-1:0]     ticks_in_phase;
    logic [WIDTH_W-1:0]     pulse_width;
    logic [SUM_W-1:0]       sum_of_widths;
    logic [4:0]             widths_taken;
    logic [DIST_W-1:0]      held_distance;

    // result words predicted and not yet seen, oldest first
    res_t                   words_due[$];
    int unsigned            words_seen;
    int unsigned            fault_count;

    // echo shaping for the pulse being generated, and sender burst state
    int unsigned            rise_delay;
    int unsigned            pulse_goal;
    int unsigned            burst_left;

    ultrasonic_echo_ranger_unit #(
        .SAMPLES         (AVG_COUNT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .echo_level      (echo_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .trigger_level   (trigger_level),
        .distance_tenths (distance_tenths),
        .distance_valid  (distance_valid),
        .sample_status   (sample_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bring the model to its post-reset state: default registers, first
    // tick of the low phase ahead of the trigger.
    function automatic void reset_ranger();
        ranger_cfg.trigger_width      = 8'd10;
        ranger_cfg.echo_start_timeout = 16'd20000;
        ranger_cfg.echo_width_timeout = 16'd30000;
        ranger_cfg.min_echo_width     = 16'd116;
        ranger_cfg.max_echo_width     = 16'd23200;
        ranger_cfg.sample_gap         = 16'd200;
        ranger_cfg.refresh_gap        = 20'd300000;
        phase_now      = RNG_PRE_LOW;
        ticks_in_phase = '0;
        pulse_width    = '0;
        sum_of_widths  = '0;
        widths_taken   = '0;
        held_distance  = '0;
    endfunction

    // Mirror one accepted register write; drop unknown indexes and keep
    // only the bits that fit the register.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_TRIGGER_WIDTH:      ranger_cfg.trigger_width      = data[TRIG_W-1:0];
            REG_ECHO_START_TIMEOUT: ranger_cfg.echo_start_timeout = data[TIMEOUT_W-1:0];
            REG_ECHO_WIDTH_TIMEOUT: ranger_cfg.echo_width_timeout = data[TIMEOUT_W-1:0];
            REG_MIN_ECHO_WIDTH:     ranger_cfg.min_echo_width     = data[WIDTH_W-1:0];
            REG_MAX_ECHO_WIDTH:     ranger_cfg.max_echo_width     = data[WIDTH_W-1:0];
            REG_SAMPLE_GAP:         ranger_cfg.sample_gap         = data[GAP_W-1:0];
            REG_REFRESH_GAP:        ranger_cfg.refresh_gap        = data[REFRESH_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void enter_phase(input ranger_phase_t next);
        phase_now      = next;
        ticks_in_phase = '0;
    endfunction

    // End of the sample gap: a full set of widths starts the refresh wait
    // (skipped when zero), otherwise trigger again.
    function automatic void leave_sample_gap();
        if (widths_taken >= AVG_COUNT)
        begin
            sum_of_widths = '0;
            widths_taken  = '0;
            enter_phase(ranger_cfg.refresh_gap == 0 ? RNG_PRE_LOW : RNG_REFRESH);
        end
        else
            enter_phase(RNG_PRE_LOW);
    endfunction

    // A measured echo ended: wait out the sample gap, or skip it when zero.
    function automatic void close_echo();
        if (ranger_cfg.sample_gap == 0)
            leave_sample_gap();
        else
            enter_phase(RNG_GAP);
    endfunction

    // Advance the model by one tick and return the word it produces.
    function automatic res_t predict_tick(input logic echo);
        res_t              word;
        logic [TRIG_W-1:0] high_ticks;
        int unsigned       tenths;
        word = '0;
        // a zero trigger width still gives one high tick
        high_ticks = (ranger_cfg.trigger_width == 0) ? 8'd1 : ranger_cfg.trigger_width;
        case (phase_now)
            RNG_PRE_LOW:
            begin
                ticks_in_phase = ticks_in_phase + 1'b1;
                if (ticks_in_phase >= PRE_LOW_TICKS)
                    enter_phase(RNG_TRIG_HIGH);
            end
            RNG_TRIG_HIGH:
            begin
                word.trigger_level = 1'b1;
                ticks_in_phase = ticks_in_phase + 1'b1;
                if (ticks_in_phase >= high_ticks)
                    enter_phase(RNG_WAIT_RISE);
            end
            RNG_WAIT_RISE:
            begin
                if (echo)
                begin
                    // the rise tick is the first high tick of the width
                    pulse_width = 16'd1;
                    enter_phase(RNG_MEASURE);
                end
                else
                begin
                    ticks_in_phase = ticks_in_phase + 1'b1;
                    if (ticks_in_phase > ranger_cfg.echo_start_timeout)
                    begin
                        word.sample_status = ST_NO_ECHO;
                        enter_phase(RNG_PRE_LOW);
                    end
                end
            end
            RNG_MEASURE:
            begin
                if (echo)
                begin
                    if (pulse_width >= ranger_cfg.echo_width_timeout)
                    begin
                        word.sample_status = ST_TOO_LONG;
                        enter_phase(RNG_PRE_LOW);
                    end
                    else
                        pulse_width = pulse_width + 1'b1;
                end
                else if (pulse_width >= ranger_cfg.min_echo_width &&
                         pulse_width <= ranger_cfg.max_echo_width)
                begin
                    word.sample_status = ST_ACCEPT;
                    sum_of_widths = sum_of_widths + pulse_width;
                    widths_taken  = widths_taken + 1'b1;
                    if (widths_taken >= AVG_COUNT)
                    begin
                        // truncated average in tenths of a centimetre, clipped to the field
                        tenths = (32'(sum_of_widths) * 32'd10) / (AVG_COUNT * TICKS_PER_CM);
                        held_distance = (tenths > DIST_MAX) ? DIST_MAX : tenths[DIST_W-1:0];
                        word.distance_valid = 1'b1;
                    end
                    close_echo();
                end
                else
                begin
                    word.sample_status = ST_RANGE;
                    close_echo();
                end
            end
            RNG_GAP:
            begin
                ticks_in_phase = ticks_in_phase + 1'b1;
                if (ticks_in_phase >= ranger_cfg.sample_gap)
                    leave_sample_gap();
            end
            RNG_REFRESH:
            begin
                ticks_in_phase = ticks_in_phase + 1'b1;
                if (ticks_in_phase >= ranger_cfg.refresh_gap)
                    enter_phase(RNG_PRE_LOW);
            end
            default:
                enter_phase(RNG_PRE_LOW);
        endcase
        word.distance_tenths = held_distance;
        return word;
    endfunction

    // Pick the next echo level from where the sequencer stands, so that most
    // pulses rise inside the listening window with a width aimed at the
    // accept range; a few land short, long, past the timeouts, or are noise.
    function automatic logic next_echo();
        int unsigned lo;
        int unsigned hi;
        int unsigned sto;
        int unsigned wto;
        int unsigned pick;
        lo  = ranger_cfg.min_echo_width;
        hi  = ranger_cfg.max_echo_width;
        sto = ranger_cfg.echo_start_timeout;
        wto = ranger_cfg.echo_width_timeout;
        if (phase_now == RNG_WAIT_RISE && ticks_in_phase == 0)
        begin
            // plan the pulse once, on the first listening tick
            if ($urandom_range(6, 0) == 0 && sto < 40)
                rise_delay = sto + 1;
            else
                rise_delay = $urandom_range(sto < 5 ? sto : 5, 0);
            pick = $urandom_range(99, 0);
            if (pick < 70 && lo <= hi)
                pulse_goal = $urandom_range(hi > lo + 30 ? lo + 30 : hi, lo);
            else if (pick < 82 && lo > 1)
                pulse_goal = $urandom_range(lo - 1, 1);
            else if (pick < 92 && hi < 60)
                pulse_goal = hi + $urandom_range(4, 1);
            else
                pulse_goal = (wto < 80) ? wto + $urandom_range(3, 1) : 80;
            if (pulse_goal < 1)
                pulse_goal = 1;
            if (pulse_goal > 80)
                pulse_goal = 80;
        end
        if ($urandom_range(24, 0) == 0)
            return logic'($urandom_range(1, 0));
        case (phase_now)
            RNG_WAIT_RISE: return ticks_in_phase >= rise_delay;
            RNG_MEASURE:   return pulse_width < pulse_goal;
            default:       return $urandom_range(9, 0) == 0;
        endcase
    endfunction

    // Offer one echo word, hold it until taken, then queue its result:
    // the spelled-out one where given, else the model's.
    task automatic send_tick(input logic echo, input bit typed, input res_t typed_word);
        res_t predicted;
        in_valid   <= 1'b1;
        echo_level <= echo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_tick(echo);
        words_due.push_back(typed ? typed_word : predicted);
    endtask

    // Send in bursts; between bursts valid may drop for a random gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
                                                     : $urandom_range(12, 1);
            gap = $urandom_range(5, 0);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
    endtask

    // Leave cfg_valid high afterwards; the caller drops it once the batch
    // is done, so that back-to-back writes never lower and raise it in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(index, data);
    endtask

    // Program a full register set on an idle block. Fill the bits above
    // each register narrower than the data word with junk to check the masking.
    task automatic load_settings(input cfg_t s);
        logic [31:0] junk;
        junk = $urandom;
        drain_pipeline();
        write_reg(REG_TRIGGER_WIDTH,      {junk[CFG_DATA_W-TRIG_W-1:0], s.trigger_width});
        write_reg(REG_ECHO_START_TIMEOUT, {junk[3:0], s.echo_start_timeout});
        write_reg(REG_ECHO_WIDTH_TIMEOUT, {junk[7:4], s.echo_width_timeout});
        write_reg(REG_MIN_ECHO_WIDTH,     {junk[11:8], s.min_echo_width});
        write_reg(REG_MAX_ECHO_WIDTH,     {junk[15:12], s.max_echo_width});
        write_reg(REG_SAMPLE_GAP,         {junk[19:16], s.sample_gap});
        write_reg(REG_REFRESH_GAP,        s.refresh_gap);
        if (junk[31:30] == 2'b00)
            write_reg(REG_UNUSED, junk[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // Short windows so that every phase comes round many times per run.
    function automatic cfg_t random_settings();
        cfg_t s;
        s.trigger_width      = TRIG_W'($urandom_range(4, 0));
        s.echo_start_timeout = TIMEOUT_W'($urandom_range(12, 0));
        s.echo_width_timeout = ($urandom_range(5, 0) == 0) ? TIMEOUT_W'($urandom_range(3, 0))
                                                           : TIMEOUT_W'($urandom_range(40, 10));
        s.min_echo_width     = WIDTH_W'($urandom_range(8, 0));
        s.max_echo_width     = ($urandom_range(9, 0) == 0)
                             ? WIDTH_W'($urandom_range(8, 0))
                             : WIDTH_W'($urandom_range(25, s.min_echo_width));
        s.sample_gap         = GAP_W'($urandom_range(6, 0));
        s.refresh_gap        = REFRESH_W'($urandom_range(12, 0));
        return s;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_INDEX_W-1:0] index,
                                              input logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.index    = index;
        r.data     = data;
        return r;
    endfunction

    function automatic script_row_t tick_row(input logic echo);
        script_row_t r;
        r      = '0;
        r.echo = echo;
        return r;
    endfunction

    // rows with a known result; no average exists yet, so distance and
    // strobe are zero
    function automatic script_row_t typed_row(input logic echo, input logic trig,
                                              input logic [STATUS_W-1:0] status);
        script_row_t r;
        r                    = '0;
        r.echo               = echo;
        r.typed              = 1'b1;
        r.word.trigger_level = trig;
        r.word.sample_status = status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: take every word the block hands over and compare it
    // with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        res_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen = words_seen + 1;
            if (words_due.size() == 0)
            begin
                fault_count = fault_count + 1;
                if (fault_count <= MAX_REPORTS)
                    $display("word %0d: result arrived with nothing pending", words_seen);
            end
            else
            begin
                due = words_due.pop_front();
                if (trigger_level !== due.trigger_level ||
                    distance_tenths !== due.distance_tenths ||
                    distance_valid !== due.distance_valid ||
                    sample_status !== due.sample_status)
                begin
                    fault_count = fault_count + 1;
                    if (fault_count <= MAX_REPORTS)
                        $display({"word %0d: expected trig %b dist %0d strobe %b status %0d,",
                                  " got trig %b dist %0d strobe %b status %0d"},
                                 words_seen, due.trigger_level, due.distance_tenths,
                                 due.distance_valid, due.sample_status, trigger_level,
                                 distance_tenths, distance_valid, sample_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall in stretches of changing character, from none at all
    // through toggling and coin flips to near-solid back-pressure.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(3, 0);
            span = $urandom_range(40, 4);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ~out_stall;
                    2:       out_stall <= ($urandom_range(1, 0) == 1);
                    default: out_stall <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end a hung run well past the slowest legal finish.
    // ------------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, scripted opening, random phases, drain, verdict.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        script_row_t script [SCRIPT_ROWS];
        cfg_t        peak;
        bit          cfg_open;
        int unsigned items;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        echo_level <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        words_seen  = 0;
        fault_count = 0;
        burst_left  = 0;
        rise_delay  = 0;
        pulse_goal  = 1;
        cfg_open    = 1'b0;
        reset_ranger();

        // Opening: two low ticks and the first trigger tick under reset
        // values, then everything zeroed (zero trigger width, zero timeouts,
        // zero waits) plus a write past the register list, walking through
        // no echo, echo too long and out of range. Last, open the window and
        // the width timeout to its top and take one accepted width.
        script = '{
            typed_row(1'b1, 1'b0, ST_NONE),
            typed_row(1'b0, 1'b0, ST_NONE),
            typed_row(1'b1, 1'b1, ST_NONE),
            write_row(REG_TRIGGER_WIDTH,      20'hFFF00),
            write_row(REG_ECHO_START_TIMEOUT, 20'hF0000),
            write_row(REG_ECHO_WIDTH_TIMEOUT, 20'h30000),
            write_row(REG_MIN_ECHO_WIDTH,     20'h00000),
            write_row(REG_MAX_ECHO_WIDTH,     20'h00000),
            write_row(REG_SAMPLE_GAP,         20'h00000),
            write_row(REG_REFRESH_GAP,        20'h00000),
            write_row(REG_UNUSED,             20'hFFFFF),
            tick_row(1'b0),
            typed_row(1'b0, 1'b0, ST_NO_ECHO),
            tick_row(1'b1),
            tick_row(1'b0),
            tick_row(1'b1),
            tick_row(1'b1),
            typed_row(1'b1, 1'b0, ST_TOO_LONG),
            tick_row(1'b1),
            tick_row(1'b0),
            tick_row(1'b0),
            tick_row(1'b1),
            tick_row(1'b0),
            write_row(REG_MAX_ECHO_WIDTH,     20'h00003),
            write_row(REG_ECHO_WIDTH_TIMEOUT, 20'h0FFFF),
            tick_row(1'b0),
            tick_row(1'b0),
            tick_row(1'b0),
            tick_row(1'b1),
            tick_row(1'b1),
            tick_row(1'b0)
        };

        // hold reset, then release it at an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                // only touch registers with nothing in flight
                if (!cfg_open)
                    drain_pipeline();
                cfg_open = 1'b1;
                write_reg(script[i].index, script[i].data);
            end
            else
            begin
                if (cfg_open)
                    cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                pace_sender();
                send_tick(script[i].echo, script[i].typed, script[i].word);
            end
        end

        // top of every register but the minimum width (zero); the long waits are entered but not sat out
        peak.trigger_width      = '1;
        peak.echo_start_timeout = '1;
        peak.echo_width_timeout = '1;
        peak.min_echo_width     = '0;
        peak.max_echo_width     = '1;
        peak.sample_gap         = '1;
        peak.refresh_gap        = '1;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PEAK_PHASE)
            begin
                load_settings(peak);
                items = 300;
            end
            else
            begin
                load_settings(random_settings());
                items = 160;
            end
            repeat (items)
            begin
                pace_sender();
                send_tick(next_echo(), 1'b0, '0);
            end
        end

        drain_pipeline();
        if (fault_count == 0 && words_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
